### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, register indexes and helpers for the lattice energy core.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int MAX_SIDE_DEF = 256;

    localparam int SIDE_W     = 9;
    localparam int COUPLING_W = 16;
    localparam int BOND_W     = 20;
    localparam int MAGNET_W   = 18;
    localparam int ENERGY_W   = 35;
    localparam int DELTA_W    = 5;   // four bond terms of +/-2

    localparam int SIDE_RST = 16;
    localparam logic signed [COUPLING_W-1:0] COUPLING_RST = 16'sd256;

    // Register indexes
    localparam logic [0:0] REG_SIDE     = 1'b0;
    localparam logic [0:0] REG_COUPLING = 1'b1;

    // Doubled bond between two spins: +2 when aligned, -2 otherwise.
    function automatic logic signed [DELTA_W-1:0] bond_term(input logic a, input logic b);
        bond_term = (a == b) ? 5'sd2 : -5'sd2;
    endfunction

endpackage

### rtl/periodic_lattice_energy_core.sv
// ----------------------------------------------------------------------------
// periodic_lattice_energy_core
// Result path: after the last spin of a lattice is taken, its sums pass the
// finish register and then the output register before the item is offered.
// Throughput: one spin item per cycle; only a stalled result holds input off.
// Line stores are read ahead at the next column, so no bubble.
// Reset: synchronous active low; side 16 (at most MAX_SIDE), coupling 1.0, scan at origin.
// ----------------------------------------------------------------------------
module periodic_lattice_energy_core #(
    parameter int MAX_SIDE = ple_pkg::MAX_SIDE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_idx,
    input  logic [ple_pkg::COUPLING_W-1:0]        i_cfg_data,
    // spin items
    input  logic                                  i_spin_valid,
    output logic                                  o_spin_ready,
    input  logic                                  i_spin,
    // result items
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output logic signed [ple_pkg::BOND_W-1:0]     o_bond_sum,
    output logic signed [ple_pkg::MAGNET_W-1:0]   o_magnetization,
    output logic signed [ple_pkg::ENERGY_W-1:0]   o_energy
);

    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int RST_LAST = ((ple_pkg::SIDE_RST > MAX_SIDE) ? MAX_SIDE
                                                              : ple_pkg::SIDE_RST) - 1;
    localparam int NEGJ_W   = ple_pkg::COUPLING_W + 1;
    localparam int PROD_W   = NEGJ_W + ple_pkg::BOND_W;

    // ------------------------------------------------------------------
    // Configuration. The side is clamped to 2..MAX_SIDE at write time and
    // kept as the index of the last row/column. Any side write restarts
    // the scan.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]                          r_last;
    logic signed [ple_pkg::COUPLING_W-1:0]     r_coupling;
    logic [31:0]                               w_cfg_side;
    logic [31:0]                               w_cfg_last;
    logic                                      w_side_wr;

    assign w_cfg_side = 32'(i_cfg_data[ple_pkg::SIDE_W-1:0]);
    assign w_side_wr  = i_cfg_we && (i_cfg_idx == ple_pkg::REG_SIDE);

    always_comb begin
        priority if (w_cfg_side < 32'd2) begin
            w_cfg_last = 32'd1;
        end else if (w_cfg_side > 32'(MAX_SIDE)) begin
            w_cfg_last = 32'(MAX_SIDE - 1);
        end else begin
            w_cfg_last = w_cfg_side - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= IDX_W'(RST_LAST);
            r_coupling <= ple_pkg::COUPLING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ple_pkg::REG_SIDE: begin
                    r_last <= w_cfg_last[IDX_W-1:0];
                end
                ple_pkg::REG_COUPLING: begin
                    r_coupling <= $signed(i_cfg_data);
                end
                default: begin
                    r_last <= r_last;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scan position and running sums
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]                       r_col, n_col;
    logic [IDX_W-1:0]                       r_row, n_row;
    logic                                   r_left;
    logic                                   r_row_start;
    logic signed [ple_pkg::BOND_W-1:0]      r_bonds, n_bonds;
    logic signed [ple_pkg::MAGNET_W-1:0]    r_magnet, n_magnet;

    logic                                   w_in_acc;
    logic                                   w_col_last;
    logic                                   w_row_last;
    logic                                   w_item_last;
    logic                                   w_prev_rd;
    logic                                   w_first_rd;
    logic signed [ple_pkg::DELTA_W-1:0]     w_delta;

    assign w_in_acc    = i_spin_valid && o_spin_ready;
    assign w_col_last  = (r_col == r_last);
    assign w_row_last  = (r_row == r_last);
    assign w_item_last = w_col_last && w_row_last;

    // bond contributions of this site: up, left, wrap to first row, wrap to row start
    always_comb begin
        w_delta = '0;
        if (r_row != '0) begin
            w_delta = w_delta + ple_pkg::bond_term(w_prev_rd, i_spin);
        end
        if (r_col != '0) begin
            w_delta = w_delta + ple_pkg::bond_term(r_left, i_spin);
        end
        if (w_row_last) begin
            w_delta = w_delta + ple_pkg::bond_term(w_first_rd, i_spin);
        end
        if (w_col_last) begin
            w_delta = w_delta + ple_pkg::bond_term(r_row_start, i_spin);
        end
    end

    assign n_bonds  = r_bonds + ple_pkg::BOND_W'(w_delta);
    assign n_magnet = r_magnet + (i_spin ? 18'sd1 : -18'sd1);

    // next position; also drives the look-ahead read of the line stores
    always_comb begin
        priority if (w_side_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (w_in_acc) begin
            n_col = w_col_last ? '0 : IDX_W'(r_col + 1'b1);
            n_row = w_col_last ? (w_row_last ? '0 : IDX_W'(r_row + 1'b1)) : r_row;
        end else begin
            n_col = r_col;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= 1'b0;
            r_row_start <= 1'b0;
            r_bonds     <= '0;
            r_magnet    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_side_wr) begin
                r_left      <= 1'b0;
                r_row_start <= 1'b0;
                r_bonds     <= '0;
                r_magnet    <= '0;
            end else if (w_in_acc) begin
                r_left <= i_spin;
                if (r_col == '0) begin
                    r_row_start <= i_spin;
                end
                // lattice complete: sums go down the result pipe, restart here
                r_bonds  <= w_item_last ? '0 : n_bonds;
                r_magnet <= w_item_last ? '0 : n_magnet;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores: previous row and first row, read at the next column.
    // ------------------------------------------------------------------
    ple_line_buf #(
        .DEPTH   (MAX_SIDE)
    ) u_prev_row (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_col),
        .i_wdata (i_spin),
        .i_raddr (n_col),
        .o_rdata (w_prev_rd)
    );

    ple_line_buf #(
        .DEPTH   (MAX_SIDE)
    ) u_first_row (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (r_row == '0)),
        .i_waddr (r_col),
        .i_wdata (i_spin),
        .i_raddr (n_col),
        .o_rdata (w_first_rd)
    );

    // ------------------------------------------------------------------
    // Result pipe: finish stage holds sums and -J, output stage multiplies.
    // ------------------------------------------------------------------
    logic                                   r_fin_valid;
    logic signed [ple_pkg::BOND_W-1:0]      r_fin_bonds;
    logic signed [ple_pkg::MAGNET_W-1:0]    r_fin_magnet;
    logic signed [NEGJ_W-1:0]               r_fin_negj;
    logic                                   r_out_valid;
    logic signed [ple_pkg::BOND_W-1:0]      r_out_bonds;
    logic signed [ple_pkg::MAGNET_W-1:0]    r_out_magnet;
    logic signed [ple_pkg::ENERGY_W-1:0]    r_out_energy;
    logic                                   w_out_load;
    logic                                   w_fin_adv;
    logic signed [PROD_W-1:0]               w_prod;

    assign w_out_load   = !r_out_valid || i_res_ready;
    assign w_fin_adv    = r_fin_valid && w_out_load;
    assign o_spin_ready = !r_fin_valid || w_out_load;
    assign w_prod       = r_fin_negj * r_fin_bonds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc && w_item_last) begin
                r_fin_valid <= 1'b1;
            end else if (w_fin_adv) begin
                r_fin_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_item_last) begin
            r_fin_bonds  <= n_bonds;
            r_fin_magnet <= n_magnet;
            r_fin_negj   <= -$signed({r_coupling[ple_pkg::COUPLING_W-1], r_coupling});
        end
        if (w_fin_adv) begin
            r_out_bonds  <= r_fin_bonds;
            r_out_magnet <= r_fin_magnet;
            r_out_energy <= w_prod[ple_pkg::ENERGY_W-1:0];
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_bond_sum      = r_out_bonds;
    assign o_magnetization = r_out_magnet;
    assign o_energy        = r_out_energy;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_SAME(a_pos_in_range, i_clk, i_rst_n, 1'b1, (r_col <= r_last) && (r_row <= r_last))
    `ASSERT_NEXT(a_last_fills_fin, i_clk, i_rst_n, w_in_acc && w_item_last, r_fin_valid)
    `ASSERT_NEXT(a_side_restarts, i_clk, i_rst_n, w_side_wr, ((r_col | r_row) == '0) && (r_bonds == '0))

endmodule

### rtl/ple_line_buf.sv
// ----------------------------------------------------------------------------
// ple_line_buf
// One-bit-wide line store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ple_line_buf #(
    parameter int DEPTH = ple_pkg::MAX_SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic                     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic                     o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
